// File: sv/waypoint_heading_guidance_top_macros.svh
// Assertion helpers for the guidance block.
`ifndef WAYPOINT_HEADING_GUIDANCE_TOP_MACROS_SVH
`define WAYPOINT_HEADING_GUIDANCE_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define WHG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("guidance assertion failed");

// Check that cons holds in the cycle after ante.
`define WHG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("guidance assertion failed");

`endif

// File: sv/whg_pkg.sv
`timescale 1ns / 1ps
package whg_pkg;

    localparam int WAYPOINT_DEPTH = 64;
    localparam int WP_AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 5;
    localparam int ANG_W = 22;
    localparam int CX_W = 36;
    localparam int MUL_W = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CFG_W = 31;
    localparam int CFG_AW = 3;

    localparam logic signed [ANG_W-1:0] Q16_PI = ANG_W'(205887);
    localparam logic signed [ANG_W-1:0] Q16_TWO_PI = ANG_W'(411775);
    localparam logic signed [ANG_W-1:0] Q16_HALF_PI = ANG_W'(102944);
    localparam logic signed [CX_W-1:0] CORDIC_GAIN_Q30 = CX_W'(652032874);

    localparam logic signed [MUL_W-1:0] K_ERR = MUL_W'(52429);
    localparam logic signed [MUL_W-1:0] K_YAW = MUL_W'(45875);
    localparam logic signed [MUL_W-1:0] K_VZ = MUL_W'(13107);
    localparam logic signed [PROD_W-1:0] S_ONE = PROD_W'(65536);

    localparam logic [1:0] FUNC_LOAD = 2'd0;
    localparam logic [1:0] FUNC_ERROR = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [CFG_AW-1:0] CFG_SPEED = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_TOL = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_YAW_LIMIT = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_ERROR_CAP = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_COUNT = 3'd4;

    typedef struct packed {
        logic [1:0]         func;
        logic [5:0]         wp_slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [15:0] heading;
        logic signed [31:0] err_x;
        logic signed [31:0] err_y;
    } whg_in_t;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic signed [15:0] yaw_rate;
        logic [6:0]         target_index;
        logic               reached;
        logic               route_done;
    } whg_out_t;

    typedef struct packed {
        logic start;
        logic vectoring;
    } whg_cordic_cmd_t;

    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:    r = ANG_W'(51472);
            5'd1:    r = ANG_W'(30386);
            5'd2:    r = ANG_W'(16055);
            5'd3:    r = ANG_W'(8150);
            5'd4:    r = ANG_W'(4091);
            5'd5:    r = ANG_W'(2047);
            5'd6:    r = ANG_W'(1024);
            5'd7:    r = ANG_W'(512);
            5'd8:    r = ANG_W'(256);
            5'd9:    r = ANG_W'(128);
            5'd10:   r = ANG_W'(64);
            5'd11:   r = ANG_W'(32);
            5'd12:   r = ANG_W'(16);
            5'd13:   r = ANG_W'(8);
            5'd14:   r = ANG_W'(4);
            5'd15:   r = ANG_W'(2);
            5'd16:   r = ANG_W'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] wrap_pi(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W-1:0] r;
        r = a;
        for (int k = 0; k < 3; k++)
        begin
            if (r > Q16_PI)
                r = r - Q16_TWO_PI;
            else if (r <= -Q16_PI)
                r = r + Q16_TWO_PI;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [15:0] r;
        if (v > PROD_W'(32767))
            r = 16'sh7fff;
        else if (v < -PROD_W'(32768))
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// File: sv/whg_cordic.sv
`timescale 1ns / 1ps
module whg_cordic (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  whg_pkg::whg_cordic_cmd_t             cmd,
    input  logic signed [whg_pkg::CX_W-1:0]      x_init,
    input  logic signed [whg_pkg::CX_W-1:0]      y_init,
    input  logic signed [whg_pkg::ANG_W-1:0]     z_init,
    output logic                                 busy,
    output logic                                 done,
    output logic signed [whg_pkg::CX_W-1:0]      x,
    output logic signed [whg_pkg::CX_W-1:0]      y,
    output logic signed [whg_pkg::ANG_W-1:0]     z
);

    logic                              busy_reg;
    logic                              done_reg;
    logic                              vec_reg;
    logic [whg_pkg::STEP_W-1:0]        step_reg;
    logic signed [whg_pkg::CX_W-1:0]   x_reg;
    logic signed [whg_pkg::CX_W-1:0]   y_reg;
    logic signed [whg_pkg::ANG_W-1:0]  z_reg;
    logic signed [whg_pkg::CX_W-1:0]   xs;
    logic signed [whg_pkg::CX_W-1:0]   ys;
    logic signed [whg_pkg::CX_W-1:0]   x_next;
    logic signed [whg_pkg::CX_W-1:0]   y_next;
    logic signed [whg_pkg::ANG_W-1:0]  z_next;
    logic signed [whg_pkg::ANG_W-1:0]  at;
    logic                              pos;
    logic                              last;

    assign last = (step_reg == whg_pkg::STEP_W'(whg_pkg::CORDIC_STEPS - 1));

    always_comb
    begin
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
        at = whg_pkg::atan_q16(step_reg);
        pos = vec_reg ? y_reg[whg_pkg::CX_W-1] : !z_reg[whg_pkg::ANG_W-1];
        if (pos)
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            vec_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                vec_reg  <= cmd.vectoring;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign x = x_reg;
    assign y = y_reg;
    assign z = z_reg;

endmodule

// File: sv/waypoint_heading_guidance_top.sv
// Waypoint heading guidance. Waypoint loads and formation error updates are taken while idle
// and produce no result. A control tick runs through one shared 34x34 multiplier and one
// shared CORDIC unit (rotation for sin/cos of the heading, then vectoring for the bearing).
// A tick after the route is complete skips both and goes straight to the output state.
// in_ready is low while a tick is in progress; a finished result waits in the output
// register while the next item is taken.
`timescale 1ns / 1ps
`include "waypoint_heading_guidance_top_macros.svh"
module waypoint_heading_guidance_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  whg_pkg::whg_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output whg_pkg::whg_out_t               out_data,
    input  logic                            cfg_we,
    input  logic [whg_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [whg_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIFF  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_WB    = 3'd3;
    localparam logic [2:0] ST_ROT   = 3'd4;
    localparam logic [2:0] ST_VEC   = 3'd5;
    localparam logic [2:0] ST_CWAIT = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic [3:0] OP_S    = 4'd0;
    localparam logic [3:0] OP_V    = 4'd1;
    localparam logic [3:0] OP_G    = 4'd2;
    localparam logic [3:0] OP_VZ   = 4'd3;
    localparam logic [3:0] OP_DX2  = 4'd4;
    localparam logic [3:0] OP_DY2  = 4'd5;
    localparam logic [3:0] OP_TOL2 = 4'd6;
    localparam logic [3:0] OP_VX   = 4'd7;
    localparam logic [3:0] OP_VY   = 4'd8;
    localparam logic [3:0] OP_YAW  = 4'd9;

    localparam int MW = whg_pkg::MUL_W;
    localparam int PW = whg_pkg::PROD_W;
    localparam int AW = whg_pkg::ANG_W;
    localparam int CW = whg_pkg::CX_W;

    logic [2:0]                state_reg;
    logic [3:0]                op_reg;
    logic                      cmode_reg;
    logic [6:0]                route_index_reg;
    logic signed [31:0]        mean_error_reg;
    logic                      out_valid_reg;
    logic [14:0]               desired_speed_reg;
    logic [30:0]               tol_reg;
    logic [14:0]               yaw_limit_reg;
    logic [30:0]               error_cap_reg;
    logic [6:0]                wp_count_reg;

    logic [95:0]               wp_mem [whg_pkg::WAYPOINT_DEPTH];
    logic [95:0]               rd_reg;
    whg_pkg::whg_in_t          item_reg;
    whg_pkg::whg_out_t         res_reg;
    whg_pkg::whg_out_t         out_reg;
    logic signed [32:0]        dx_reg;
    logic signed [32:0]        dy_reg;
    logic signed [32:0]        dz_reg;
    logic signed [MW-1:0]      s_reg;
    logic signed [MW-1:0]      v_reg;
    logic signed [MW-1:0]      g_reg;
    logic signed [MW-1:0]      c_reg;
    logic signed [MW-1:0]      sn_reg;
    logic signed [AW-1:0]      e_reg;
    logic [63:0]               sq_reg;
    logic signed [PW-1:0]      prod_reg;
    logic                      neg_reg;

    logic [6:0]                count_eff;
    logic                      route_over;
    logic signed [32:0]        err_sum;
    logic signed [31:0]        mean_next;
    logic signed [32:0]        adx;
    logic signed [32:0]        ady;
    logic                      near_w;
    logic                      zero_w;
    logic                      reached_now;
    logic signed [MW-1:0]      mul_a;
    logic signed [MW-1:0]      mul_b;
    logic signed [PW-1:0]      mprod;
    logic signed [PW-1:0]      yaw_full;
    logic signed [PW-1:0]      yaw_lim;
    logic signed [15:0]        yaw_cl;
    logic signed [AW-1:0]      hd8;
    logic signed [AW-1:0]      hd_wrap;
    logic signed [AW-1:0]      fold_z;
    logic                      fold_neg;
    logic signed [AW-1:0]      z_final;

    whg_pkg::whg_cordic_cmd_t  cord_cmd;
    logic signed [CW-1:0]      cord_x0;
    logic signed [CW-1:0]      cord_y0;
    logic signed [AW-1:0]      cord_z0;
    logic                      cord_busy;
    logic                      cord_done;
    logic signed [CW-1:0]      cord_x;
    logic signed [CW-1:0]      cord_y;
    logic signed [AW-1:0]      cord_z;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    assign count_eff = (int'(wp_count_reg) < whg_pkg::WAYPOINT_DEPTH) ? wp_count_reg
                                                                       : 7'(whg_pkg::WAYPOINT_DEPTH);
    assign route_over = (route_index_reg >= count_eff);

    assign err_sum = 33'(in_data.err_x) + 33'(in_data.err_y);
    assign mean_next = ($signed(err_sum[32:1]) > $signed({1'b0, error_cap_reg})) ?
                       $signed({1'b0, error_cap_reg}) : $signed(err_sum[32:1]);

    assign adx = dx_reg[32] ? -dx_reg : dx_reg;
    assign ady = dy_reg[32] ? -dy_reg : dy_reg;
    assign near_w = (adx[32:31] == 2'b00) && (ady[32:31] == 2'b00);
    assign zero_w = (dx_reg == '0) && (dy_reg == '0);
    assign reached_now = near_w && (sq_reg < prod_reg[63:0]);

    always_comb
    begin
        case (op_reg)
            OP_S:
            begin
                mul_a = whg_pkg::K_ERR;
                mul_b = MW'(mean_error_reg);
            end
            OP_V:
            begin
                mul_a = MW'($signed({1'b0, desired_speed_reg}));
                mul_b = s_reg;
            end
            OP_G:
            begin
                mul_a = whg_pkg::K_YAW;
                mul_b = s_reg;
            end
            OP_VZ:
            begin
                mul_a = whg_pkg::K_VZ;
                mul_b = MW'(dz_reg);
            end
            OP_DX2:
            begin
                mul_a = MW'($signed({1'b0, adx[30:0]}));
                mul_b = MW'($signed({1'b0, adx[30:0]}));
            end
            OP_DY2:
            begin
                mul_a = MW'($signed({1'b0, ady[30:0]}));
                mul_b = MW'($signed({1'b0, ady[30:0]}));
            end
            OP_TOL2:
            begin
                mul_a = MW'($signed({1'b0, tol_reg}));
                mul_b = MW'($signed({1'b0, tol_reg}));
            end
            OP_VX:
            begin
                mul_a = v_reg;
                mul_b = c_reg;
            end
            OP_VY:
            begin
                mul_a = v_reg;
                mul_b = sn_reg;
            end
            OP_YAW:
            begin
                mul_a = g_reg;
                mul_b = MW'(e_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mprod = mul_a * mul_b;

    always_comb
    begin
        yaw_full = prod_reg >>> 20;
        yaw_lim = PW'($signed({1'b0, yaw_limit_reg}));
        if (yaw_full > yaw_lim)
            yaw_cl = yaw_lim[15:0];
        else if (yaw_full < -yaw_lim)
            yaw_cl = -yaw_lim[15:0];
        else
            yaw_cl = yaw_full[15:0];
    end

    always_comb
    begin
        hd8 = AW'(item_reg.heading) <<< 3;
        hd_wrap = whg_pkg::wrap_pi(hd8);
        if (hd_wrap > whg_pkg::Q16_HALF_PI)
        begin
            fold_z = hd_wrap - whg_pkg::Q16_PI;
            fold_neg = 1'b1;
        end
        else if (hd_wrap < -whg_pkg::Q16_HALF_PI)
        begin
            fold_z = hd_wrap + whg_pkg::Q16_PI;
            fold_neg = 1'b1;
        end
        else
        begin
            fold_z = hd_wrap;
            fold_neg = 1'b0;
        end
        z_final = zero_w ? '0 : cord_z;
    end

    always_comb
    begin
        cord_cmd.start = (state_reg == ST_ROT) || (state_reg == ST_VEC);
        cord_cmd.vectoring = (state_reg == ST_VEC);
        if (state_reg == ST_VEC)
        begin
            if (dx_reg[32])
            begin
                cord_x0 = -CW'(dx_reg);
                cord_y0 = -CW'(dy_reg);
                cord_z0 = dy_reg[32] ? -whg_pkg::Q16_PI : whg_pkg::Q16_PI;
            end
            else
            begin
                cord_x0 = CW'(dx_reg);
                cord_y0 = CW'(dy_reg);
                cord_z0 = '0;
            end
        end
        else
        begin
            cord_x0 = whg_pkg::CORDIC_GAIN_Q30;
            cord_y0 = '0;
            cord_z0 = fold_z;
        end
    end

    whg_cordic u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cord_cmd),
        .x_init (cord_x0),
        .y_init (cord_y0),
        .z_init (cord_z0),
        .busy   (cord_busy),
        .done   (cord_done),
        .x      (cord_x),
        .y      (cord_y),
        .z      (cord_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            op_reg            <= OP_S;
            cmode_reg         <= 1'b0;
            route_index_reg   <= '0;
            mean_error_reg    <= '0;
            out_valid_reg     <= 1'b0;
            desired_speed_reg <= 15'd4096;
            tol_reg           <= 31'd19661;
            yaw_limit_reg     <= 15'd1229;
            error_cap_reg     <= 31'd65536;
            wp_count_reg      <= 7'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    whg_pkg::CFG_SPEED:     desired_speed_reg <= cfg_wdata[14:0];
                    whg_pkg::CFG_TOL:       tol_reg <= cfg_wdata[30:0];
                    whg_pkg::CFG_YAW_LIMIT: yaw_limit_reg <= cfg_wdata[14:0];
                    whg_pkg::CFG_ERROR_CAP: error_cap_reg <= cfg_wdata[30:0];
                    whg_pkg::CFG_COUNT:     wp_count_reg <= cfg_wdata[6:0];
                    default:                ;
                endcase
            end
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (in_data.func == whg_pkg::FUNC_ERROR)
                            mean_error_reg <= mean_next;
                        else if (in_data.func == whg_pkg::FUNC_TICK)
                            state_reg <= route_over ? ST_OUT : ST_DIFF;
                    end
                end
                ST_DIFF:
                begin
                    op_reg <= OP_S;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    if (op_reg == OP_TOL2 && reached_now)
                        route_index_reg <= route_index_reg + 7'd1;
                    case (op_reg)
                        OP_TOL2: state_reg <= ST_ROT;
                        OP_VY:   state_reg <= ST_VEC;
                        OP_YAW:  state_reg <= ST_OUT;
                        default:
                        begin
                            op_reg <= op_reg + 4'd1;
                            state_reg <= ST_MUL;
                        end
                    endcase
                end
                ST_ROT:
                begin
                    cmode_reg <= 1'b0;
                    state_reg <= ST_CWAIT;
                end
                ST_VEC:
                begin
                    cmode_reg <= 1'b1;
                    state_reg <= ST_CWAIT;
                end
                ST_CWAIT:
                begin
                    if (cord_done)
                    begin
                        op_reg <= cmode_reg ? OP_YAW : OP_VX;
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= wp_mem[whg_pkg::WP_AW'(route_index_reg)];
        if (in_valid && in_ready && in_data.func == whg_pkg::FUNC_LOAD
            && int'(in_data.wp_slot) < whg_pkg::WAYPOINT_DEPTH)
        begin
            wp_mem[whg_pkg::WP_AW'(in_data.wp_slot)] <=
                {in_data.coord_x, in_data.coord_y, in_data.coord_z};
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
            out_reg <= res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                res_reg.vel_x        <= '0;
                res_reg.vel_y        <= '0;
                res_reg.vel_z        <= '0;
                res_reg.yaw_rate     <= '0;
                res_reg.target_index <= route_index_reg;
                res_reg.reached      <= 1'b0;
                res_reg.route_done   <= 1'b1;
            end
            ST_DIFF:
            begin
                dx_reg <= 33'($signed(rd_reg[95:64])) - 33'(item_reg.coord_x);
                dy_reg <= 33'($signed(rd_reg[63:32])) - 33'(item_reg.coord_y);
                dz_reg <= 33'($signed(rd_reg[31:0])) - 33'(item_reg.coord_z);
                res_reg.route_done <= 1'b0;
            end
            ST_MUL:
            begin
                prod_reg <= mprod;
            end
            ST_WB:
            begin
                case (op_reg)
                    OP_S:    s_reg <= MW'(whg_pkg::S_ONE - (prod_reg >>> 16));
                    OP_V:    v_reg <= MW'(prod_reg >>> 16);
                    OP_G:    g_reg <= MW'(prod_reg >>> 16);
                    OP_VZ:   res_reg.vel_z <= whg_pkg::sat16(prod_reg >>> 20);
                    OP_DX2:  sq_reg <= prod_reg[63:0];
                    OP_DY2:  sq_reg <= sq_reg + prod_reg[63:0];
                    OP_TOL2:
                    begin
                        res_reg.reached <= reached_now;
                        res_reg.target_index <= reached_now ? route_index_reg + 7'd1
                                                            : route_index_reg;
                    end
                    OP_VX:   res_reg.vel_x <= whg_pkg::sat16(prod_reg >>> 30);
                    OP_VY:   res_reg.vel_y <= whg_pkg::sat16(prod_reg >>> 30);
                    OP_YAW:  res_reg.yaw_rate <= yaw_cl;
                    default: ;
                endcase
            end
            ST_ROT:
            begin
                neg_reg <= fold_neg;
            end
            ST_CWAIT:
            begin
                if (cord_done && !cmode_reg)
                begin
                    c_reg  <= neg_reg ? MW'(-cord_x) : MW'(cord_x);
                    sn_reg <= neg_reg ? MW'(-cord_y) : MW'(cord_y);
                end
                if (cord_done && cmode_reg)
                    e_reg <= whg_pkg::wrap_pi(z_final - hd8);
            end
            default: ;
        endcase
    end

    `WHG_ASSERT_IMP(a_idle_cordic_quiet, in_ready, !cord_busy)
    `WHG_ASSERT_NXT(a_tick_blocks, in_valid && in_ready && in_data.func == whg_pkg::FUNC_TICK, !in_ready)
    `WHG_ASSERT_IMP(a_done_zero, out_valid && out_data.route_done, !out_data.reached && out_data.yaw_rate == 16'sd0)
    `WHG_ASSERT_IMP(a_index_step, route_index_reg != $past(route_index_reg), route_index_reg == $past(route_index_reg) + 7'd1)
    `WHG_ASSERT_IMP(a_yaw_limit, out_valid, out_data.yaw_rate <= $signed({1'b0, yaw_limit_reg}) && out_data.yaw_rate >= -$signed({1'b0, yaw_limit_reg}))

endmodule
